// ----- rtl/phig_pkg.sv -----
// Package for the periodic halo index generator.
// Holds field widths, request and status codes, register indexes and the
// command and status structs that join the controller and the datapath.
`default_nettype none

package phig_pkg;

  localparam int COORD_W   = 11;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int BS_W      = 5;
  localparam int STAT_W    = 2;
  localparam int IDX_W     = 34;
  localparam int CUR_W     = 13;
  localparam int WRAP_W    = 14;

  localparam int DEF_MAX_AXIS_SIZE = 1024;
  localparam int DEF_MAX_BLOCK     = 16;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_NEXT  = 1'b1;

  localparam logic [STAT_W-1:0] ST_INDEX  = 2'd0;
  localparam logic [STAT_W-1:0] ST_ACCEPT = 2'd1;
  localparam logic [STAT_W-1:0] ST_REJECT = 2'd2;
  localparam logic [STAT_W-1:0] ST_IDLE   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 2'd3;

  typedef struct packed {
    logic accept;
    logic mul_plane;
    logic mul_depth;
    logic sum_node;
    logic mul_block;
    logic emit;
  } phig_cmd_t;

  typedef struct packed {
    logic need_calc;
  } phig_sts_t;

endpackage

`default_nettype wire

// ----- rtl/phig_ctrl.sv -----
// Controller of the periodic halo index generator.
// Sequences the multiply and sum steps of the datapath and owns both handshakes.
// Depends on phig_pkg.
`default_nettype none

module phig_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  input  wire phig_pkg::phig_sts_t  sts,
  output phig_pkg::phig_cmd_t       cmd
);
  import phig_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PLANE = 3'd1;
  localparam logic [2:0] S_DEPTH = 3'd2;
  localparam logic [2:0] S_SUM   = 3'd3;
  localparam logic [2:0] S_BLOCK = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.accept    = (state_r == S_IDLE) && in_valid;
    cmd.mul_plane = (state_r == S_PLANE);
    cmd.mul_depth = (state_r == S_DEPTH);
    cmd.sum_node  = (state_r == S_SUM);
    cmd.mul_block = (state_r == S_BLOCK);
    cmd.emit      = (state_r == S_FIN) && out_free;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.need_calc ? S_PLANE : S_FIN;
        end
      end
      S_PLANE: state_nxt = S_DEPTH;
      S_DEPTH: state_nxt = S_SUM;
      S_SUM:   state_nxt = S_BLOCK;
      S_BLOCK: state_nxt = S_FIN;
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/phig_dp.sv -----
// Datapath of the periodic halo index generator.
// Holds the configuration registers, the walk state, the multiply chain and
// the result register. Depends on phig_pkg.
`default_nettype none

module phig_dp #(
  parameter int MAX_AXIS_SIZE = phig_pkg::DEF_MAX_AXIS_SIZE,
  parameter int MAX_BLOCK     = phig_pkg::DEF_MAX_BLOCK
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   cfg_wr_en,
  input  wire logic        [phig_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic        [phig_pkg::CFG_W-1:0]      cfg_data,
  input  wire logic                                   in_req_type,
  input  wire logic signed [phig_pkg::COORD_W-1:0]    in_start_x,
  input  wire logic signed [phig_pkg::COORD_W-1:0]    in_start_y,
  input  wire logic signed [phig_pkg::COORD_W-1:0]    in_start_z,
  input  wire logic        [phig_pkg::COORD_W-1:0]    in_width_x,
  input  wire logic        [phig_pkg::COORD_W-1:0]    in_width_y,
  input  wire logic        [phig_pkg::COORD_W-1:0]    in_width_z,
  input  wire phig_pkg::phig_cmd_t                    cmd,
  output phig_pkg::phig_sts_t                         sts,
  output logic             [phig_pkg::STAT_W-1:0]     out_status,
  output logic             [phig_pkg::IDX_W-1:0]      out_linear_index,
  output logic                                        out_last
);
  import phig_pkg::*;

  localparam logic [16:0] MAX_AX  = 17'(MAX_AXIS_SIZE);
  localparam logic [8:0]  MAX_BLK = 9'(MAX_BLOCK);

  function automatic logic axis_ok(input logic [CFG_W-1:0] size,
                                   input logic signed [CUR_W-1:0] start,
                                   input logic [CFG_W-1:0] width);
    logic signed [CUR_W-1:0] sz;
    logic signed [CUR_W-1:0] lim;
    logic signed [CUR_W-1:0] fin;
    logic                    ok;
    begin
      sz  = $signed({2'b00, size});
      lim = $signed({1'b0, size, 1'b0});
      fin = start + $signed({2'b00, width});
      ok  = (size != '0) && (17'(size) <= MAX_AX) && (width != '0);
      ok  = ok && !(start < -sz) && !(fin > lim);
      return ok;
    end
  endfunction

  function automatic logic signed [WRAP_W-1:0] wrap_axis(
      input logic signed [CUR_W-1:0] v, input logic [CFG_W-1:0] size);
    logic signed [WRAP_W-1:0] r;
    logic signed [WRAP_W-1:0] s;
    begin
      r = $signed({v[CUR_W-1], v});
      s = $signed({3'b000, size});
      if (r < 0) begin
        r = r + s;
      end else if (r >= s) begin
        r = r - s;
      end
      return r;
    end
  endfunction

  logic [CFG_W-1:0] size_x_r, size_y_r, size_z_r;
  logic [BS_W-1:0]  bs_r;

  logic                    active_r, active_nxt;
  logic signed [CUR_W-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt, cur_z_r, cur_z_nxt;
  logic [BS_W-1:0]         comp_r, comp_nxt;
  logic signed [CUR_W-1:0] first_x_r, first_x_nxt, first_y_r, first_y_nxt;
  logic signed [CUR_W-1:0] end_x_r, end_x_nxt, end_y_r, end_y_nxt, end_z_r, end_z_nxt;

  logic [STAT_W-1:0] res_status_nxt;
  logic              res_last_nxt;

  logic signed [CUR_W-1:0] sx, sy, sz;
  logic                    box_ok;
  logic [BS_W:0]           comp_inc;
  logic signed [CUR_W-1:0] x_inc, y_inc, z_inc;

  logic signed [WRAP_W-1:0]  gx_r, gy_r, gz_r;
  logic [BS_W-1:0]           calc_comp_r;
  logic signed [25:0]        p_yx_r;
  logic [2*CFG_W-1:0]        p_xy_r;
  logic [IDX_W-1:0]          p_z_r;
  logic signed [36:0]        p_z_full;
  logic [IDX_W-1:0]          node_r;
  logic [STAT_W-1:0]         res_status_r;
  logic [IDX_W-1:0]          res_idx_r;
  logic                      res_last_r;

  assign sx = $signed({{2{in_start_x[COORD_W-1]}}, in_start_x});
  assign sy = $signed({{2{in_start_y[COORD_W-1]}}, in_start_y});
  assign sz = $signed({{2{in_start_z[COORD_W-1]}}, in_start_z});

  assign box_ok = axis_ok(size_x_r, sx, in_width_x) && axis_ok(size_y_r, sy, in_width_y) &&
                  axis_ok(size_z_r, sz, in_width_z) && (bs_r != '0) &&
                  (9'(bs_r) <= MAX_BLK);

  assign sts.need_calc = (in_req_type == REQ_NEXT) && active_r;

  assign comp_inc = {1'b0, comp_r} + 1'b1;
  assign x_inc    = cur_x_r + $signed(CUR_W'(1));
  assign y_inc    = cur_y_r + $signed(CUR_W'(1));
  assign z_inc    = cur_z_r + $signed(CUR_W'(1));

  always_comb begin
    active_nxt     = active_r;
    cur_x_nxt      = cur_x_r;
    cur_y_nxt      = cur_y_r;
    cur_z_nxt      = cur_z_r;
    comp_nxt       = comp_r;
    first_x_nxt    = first_x_r;
    first_y_nxt    = first_y_r;
    end_x_nxt      = end_x_r;
    end_y_nxt      = end_y_r;
    end_z_nxt      = end_z_r;
    res_status_nxt = ST_IDLE;
    res_last_nxt   = 1'b0;
    if (in_req_type == REQ_START) begin
      if (box_ok) begin
        active_nxt     = 1'b1;
        first_x_nxt    = sx;
        first_y_nxt    = sy;
        end_x_nxt      = sx + $signed({2'b00, in_width_x});
        end_y_nxt      = sy + $signed({2'b00, in_width_y});
        end_z_nxt      = sz + $signed({2'b00, in_width_z});
        cur_x_nxt      = sx;
        cur_y_nxt      = sy;
        cur_z_nxt      = sz;
        comp_nxt       = '0;
        res_status_nxt = ST_ACCEPT;
      end else begin
        active_nxt     = 1'b0;
        res_status_nxt = ST_REJECT;
      end
    end else if (active_r) begin
      res_status_nxt = ST_INDEX;
      if (comp_inc < {1'b0, bs_r}) begin
        comp_nxt = comp_inc[BS_W-1:0];
      end else begin
        comp_nxt  = '0;
        cur_x_nxt = x_inc;
        if (x_inc >= end_x_r) begin
          cur_x_nxt = first_x_r;
          cur_y_nxt = y_inc;
          if (y_inc >= end_y_r) begin
            cur_y_nxt = first_y_r;
            cur_z_nxt = z_inc;
            if (z_inc >= end_z_r) begin
              active_nxt   = 1'b0;
              res_last_nxt = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= CFG_W'(1);
      size_y_r <= CFG_W'(1);
      size_z_r <= CFG_W'(1);
      bs_r     <= BS_W'(1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SIZE_X:     size_x_r <= cfg_data;
        CFG_SIZE_Y:     size_y_r <= cfg_data;
        CFG_SIZE_Z:     size_z_r <= cfg_data;
        CFG_BLOCK_SIZE: bs_r     <= cfg_data[BS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (cmd.accept) begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_x_r      <= cur_x_nxt;
      cur_y_r      <= cur_y_nxt;
      cur_z_r      <= cur_z_nxt;
      comp_r       <= comp_nxt;
      first_x_r    <= first_x_nxt;
      first_y_r    <= first_y_nxt;
      end_x_r      <= end_x_nxt;
      end_y_r      <= end_y_nxt;
      end_z_r      <= end_z_nxt;
      res_status_r <= res_status_nxt;
      res_last_r   <= res_last_nxt;
      res_idx_r    <= '0;
      gx_r         <= wrap_axis(cur_x_r, size_x_r);
      gy_r         <= wrap_axis(cur_y_r, size_y_r);
      gz_r         <= wrap_axis(cur_z_r, size_z_r);
      calc_comp_r  <= comp_r;
    end
    if (cmd.mul_plane) begin
      p_yx_r <= gy_r * $signed({1'b0, size_x_r});
      p_xy_r <= size_x_r * size_y_r;
    end
    if (cmd.mul_depth) begin
      p_z_r <= p_z_full[IDX_W-1:0];
    end
    if (cmd.sum_node) begin
      node_r <= IDX_W'(gx_r) + IDX_W'(p_yx_r) + p_z_r;
    end
    if (cmd.mul_block) begin
      res_idx_r <= node_r * IDX_W'(bs_r) + IDX_W'(calc_comp_r);
    end
    if (cmd.emit) begin
      out_status       <= res_status_r;
      out_linear_index <= res_idx_r;
      out_last         <= res_last_r;
    end
  end

  assign p_z_full = gz_r * $signed({1'b0, p_xy_r});

endmodule

`default_nettype wire

// ----- rtl/periodic_halo_index_generator.sv -----
// Periodic halo index generator: top level joining controller and datapath.
// A start request, or a next request with no walk running, goes from idle straight to the
// finish state, where its result is registered; an index first passes the plane and depth
// multiplies, the node sum and the block multiply, each in a state of its own.
// One request at a time: in_stall is high whenever the controller is not idle, so the next
// transfer is taken only after the result is emitted, and it waits on out_stall as well.
`default_nettype none

module periodic_halo_index_generator #(
  parameter int MAX_AXIS_SIZE = phig_pkg::DEF_MAX_AXIS_SIZE,
  parameter int MAX_BLOCK     = phig_pkg::DEF_MAX_BLOCK
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   cfg_wr_en,
  input  wire logic        [phig_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic        [phig_pkg::CFG_W-1:0]      cfg_data,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic                                   in_req_type,
  input  wire logic signed [phig_pkg::COORD_W-1:0]    in_start_x,
  input  wire logic signed [phig_pkg::COORD_W-1:0]    in_start_y,
  input  wire logic signed [phig_pkg::COORD_W-1:0]    in_start_z,
  input  wire logic        [phig_pkg::COORD_W-1:0]    in_width_x,
  input  wire logic        [phig_pkg::COORD_W-1:0]    in_width_y,
  input  wire logic        [phig_pkg::COORD_W-1:0]    in_width_z,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic             [phig_pkg::STAT_W-1:0]     out_status,
  output logic             [phig_pkg::IDX_W-1:0]      out_linear_index,
  output logic                                        out_last
);
  import phig_pkg::*;

  phig_cmd_t cmd;
  phig_sts_t sts;

  phig_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  phig_dp #(
    .MAX_AXIS_SIZE (MAX_AXIS_SIZE),
    .MAX_BLOCK     (MAX_BLOCK)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_req_type      (in_req_type),
    .in_start_x       (in_start_x),
    .in_start_y       (in_start_y),
    .in_start_z       (in_start_z),
    .in_width_x       (in_width_x),
    .in_width_y       (in_width_y),
    .in_width_z       (in_width_z),
    .cmd              (cmd),
    .sts              (sts),
    .out_status       (out_status),
    .out_linear_index (out_linear_index),
    .out_last         (out_last)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("A second transfer was taken while a request was in work.");

  a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_INDEX || out_linear_index == '0))
    else $error("A non-index result carries a nonzero index.");

  a_last_on_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_status == ST_INDEX)
    else $error("The last mark is set on a result that is not an index.");

endmodule

`default_nettype wire

// ----- tb/phig_checker.sv -----
// Checker for the periodic halo index generator: watches the register port and both channels.
// It keeps its own copy of the box walk, predicts one result per request transfer and
// compares each result transfer with the oldest prediction. Depends on phig_pkg.
`timescale 1ns / 1ps

module phig_checker (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_wr_en,
  input  wire logic        [phig_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic        [phig_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                                  in_valid,
  input  wire logic                                  in_stall,
  input  wire logic                                  in_req_type,
  input  wire logic signed [phig_pkg::COORD_W-1:0]   in_start_x,
  input  wire logic signed [phig_pkg::COORD_W-1:0]   in_start_y,
  input  wire logic signed [phig_pkg::COORD_W-1:0]   in_start_z,
  input  wire logic        [phig_pkg::COORD_W-1:0]   in_width_x,
  input  wire logic        [phig_pkg::COORD_W-1:0]   in_width_y,
  input  wire logic        [phig_pkg::COORD_W-1:0]   in_width_z,
  input  wire logic                                  out_valid,
  input  wire logic                                  out_stall,
  input  wire logic        [phig_pkg::STAT_W-1:0]    out_status,
  input  wire logic        [phig_pkg::IDX_W-1:0]     out_linear_index,
  input  wire logic                                  out_last,
  output int                                         mismatches,
  output int                                         results_seen
);
  import phig_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  index;
    logic              last;
  } index_result_t;

  index_result_t pending_results[$];

  int unsigned grid_x = 1, grid_y = 1, grid_z = 1, comps = 1;
  bit          walking = 1'b0;
  int          pos_x, pos_y, pos_z;
  int unsigned comp;
  int          first_x, first_y, end_x, end_y, end_z;

  function automatic bit axis_fits(int unsigned size, int start, int unsigned width);
    if (size == 0 || size > DEF_MAX_AXIS_SIZE) return 1'b0;
    if (width == 0) return 1'b0;
    if (start < -int'(size)) return 1'b0;
    if (start + int'(width) > 2 * int'(size)) return 1'b0;
    return 1'b1;
  endfunction

  function automatic longint fold(int v, int unsigned size);
    longint r, s;
    r = v;
    s = size;
    if (r < 0) r = r + s;
    else if (r >= s) r = r - s;
    return r;
  endfunction

  task automatic walk_step(input logic kind, input int sx, sy, sz,
                           input int unsigned wx, wy, wz);
    index_result_t r;
    longint node;
    r.status = ST_IDLE;
    r.index  = '0;
    r.last   = 1'b0;
    if (kind == REQ_START) begin
      if (axis_fits(grid_x, sx, wx) && axis_fits(grid_y, sy, wy) &&
          axis_fits(grid_z, sz, wz) && comps != 0 && comps <= DEF_MAX_BLOCK) begin
        walking = 1'b1;
        first_x = sx;
        first_y = sy;
        end_x   = sx + int'(wx);
        end_y   = sy + int'(wy);
        end_z   = sz + int'(wz);
        pos_x   = sx;
        pos_y   = sy;
        pos_z   = sz;
        comp    = 0;
        r.status = ST_ACCEPT;
      end else begin
        walking  = 1'b0;
        r.status = ST_REJECT;
      end
    end else if (walking) begin
      node = fold(pos_x, grid_x) + fold(pos_y, grid_y) * longint'(grid_x) +
             fold(pos_z, grid_z) * longint'(grid_x) * longint'(grid_y);
      r.index  = IDX_W'(longint'(comp) + longint'(comps) * node);
      r.status = ST_INDEX;
      if (comp + 1 < comps) begin
        comp++;
      end else begin
        comp = 0;
        pos_x++;
        if (pos_x >= end_x) begin
          pos_x = first_x;
          pos_y++;
          if (pos_y >= end_y) begin
            pos_y = first_y;
            pos_z++;
            if (pos_z >= end_z) begin
              walking = 1'b0;
              r.last  = 1'b1;
            end
          end
        end
      end
    end
    pending_results.push_back(r);
  endtask

  always @(posedge clk) begin : monitor
    index_result_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      grid_x  = 1;
      grid_y  = 1;
      grid_z  = 1;
      comps   = 1;
      walking = 1'b0;
      pending_results.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_SIZE_X:     grid_x = cfg_data;
          CFG_SIZE_Y:     grid_y = cfg_data;
          CFG_SIZE_Z:     grid_z = cfg_data;
          CFG_BLOCK_SIZE: comps  = cfg_data[BS_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (pending_results.size() == 0) begin
          $error("result transfer with no request outstanding: status %0d, index %0d",
                 out_status, out_linear_index);
          errs++;
        end else begin
          want = pending_results.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_status);
            errs++;
          end
          if (out_linear_index !== want.index) begin
            $error("linear_index: expected %0d, actual %0d", want.index, out_linear_index);
            errs++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, out_last);
            errs++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        walk_step(in_req_type, in_start_x, in_start_y, in_start_z,
                  in_width_x, in_width_y, in_width_z);
      end
    end
    if (errs != 0) mismatches <= mismatches + errs;
  end

endmodule

// ----- tb/periodic_halo_index_generator_tb.sv -----
// Testbench top for the periodic halo index generator: clock, reset, register writes and
// request stimulus with bursty transfers and a stalling receiver. Checking is done by
// phig_checker; this module only gives the verdict. Depends on phig_pkg and the block.
`timescale 1ns / 1ps

module periodic_halo_index_generator_tb;
  import phig_pkg::*;

  logic                      clk         = 1'b0;
  logic                      rst_n       = 1'b0;
  logic                      cfg_wr_en   = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index   = CFG_SIZE_X;
  logic [CFG_W-1:0]          cfg_data    = '0;
  logic                      in_valid    = 1'b0;
  logic                      in_stall;
  logic                      in_req_type = REQ_NEXT;
  logic signed [COORD_W-1:0] in_start_x  = '0;
  logic signed [COORD_W-1:0] in_start_y  = '0;
  logic signed [COORD_W-1:0] in_start_z  = '0;
  logic [COORD_W-1:0]        in_width_x  = '0;
  logic [COORD_W-1:0]        in_width_y  = '0;
  logic [COORD_W-1:0]        in_width_z  = '0;
  logic                      out_valid;
  logic                      out_stall   = 1'b0;
  logic [STAT_W-1:0]         out_status;
  logic [IDX_W-1:0]          out_linear_index;
  logic                      out_last;

  int mismatches;
  int results_seen;
  int requests_sent = 0;
  int settings_used = 0;
  int burst_left    = 0;
  int stall_left    = 0;
  int stall_mode    = 0;
  int reg_x = 1, reg_y = 1, reg_z = 1, reg_bs = 1;
  bit regs_ok = 1'b1;

  always #10 clk = ~clk;

  periodic_halo_index_generator i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_start_x       (in_start_x),
    .in_start_y       (in_start_y),
    .in_start_z       (in_start_z),
    .in_width_x       (in_width_x),
    .in_width_y       (in_width_y),
    .in_width_z       (in_width_z),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_linear_index (out_linear_index),
    .out_last         (out_last)
  );

  phig_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_start_x       (in_start_x),
    .in_start_y       (in_start_y),
    .in_start_z       (in_start_z),
    .in_width_x       (in_width_x),
    .in_width_y       (in_width_y),
    .in_width_z       (in_width_z),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_linear_index (out_linear_index),
    .out_last         (out_last),
    .mismatches       (mismatches),
    .results_seen     (results_seen)
  );

  // The receiver switches between free running, light and heavy random stalls and
  // regular stall runs.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(16, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= ((stall_left % 6) < 3);
    endcase
  end

  task automatic put(input logic kind, input int sx, sy, sz, wx, wy, wz);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid    <= 1'b1;
    in_req_type <= kind;
    in_start_x  <= sx[COORD_W-1:0];
    in_start_y  <= sy[COORD_W-1:0];
    in_start_z  <= sz[COORD_W-1:0];
    in_width_x  <= wx[COORD_W-1:0];
    in_width_y  <= wy[COORD_W-1:0];
    in_width_z  <= wz[COORD_W-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
    burst_left--;
  endtask

  task automatic put_next();
    put(REQ_NEXT, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_seen != requests_sent) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data[CFG_W-1:0];
    @(posedge clk);
  endtask

  task automatic program_regs(input int sx, sy, sz, bs_data);
    put_reg(CFG_SIZE_X, sx);
    put_reg(CFG_SIZE_Y, sy);
    put_reg(CFG_SIZE_Z, sz);
    put_reg(CFG_BLOCK_SIZE, bs_data);
    cfg_wr_en <= 1'b0;
    reg_x   = sx % 2048;
    reg_y   = sy % 2048;
    reg_z   = sz % 2048;
    reg_bs  = bs_data % 32;
    regs_ok = reg_x >= 1 && reg_x <= DEF_MAX_AXIS_SIZE && reg_y >= 1 &&
              reg_y <= DEF_MAX_AXIS_SIZE && reg_z >= 1 && reg_z <= DEF_MAX_AXIS_SIZE &&
              reg_bs >= 1 && reg_bs <= DEF_MAX_BLOCK;
    settings_used++;
  endtask

  function automatic int box_origin(int size, int width);
    int lo, hi;
    lo = -size;
    hi = 2 * size - width;
    if (lo < -1024) lo = -1024;
    if (hi > 1023) hi = 1023;
    if (hi < lo) return lo;
    case ($urandom_range(0, 3))
      0:       return lo;
      1:       return hi;
      default: return lo + int'($urandom_range(0, hi - lo));
    endcase
  endfunction

  function automatic int grow(int v);
    return v + int'($urandom_range(0, (v > 512) ? 1024 - v : v));
  endfunction

  task automatic run_walk(input bit to_end);
    int wx, wy, wz, bs, steps, done;
    wx = $urandom_range(1, (reg_x == 1) ? 3 : 4);
    wy = $urandom_range(1, 3);
    wz = $urandom_range(1, 2);
    bs = (reg_bs >= 1 && reg_bs <= DEF_MAX_BLOCK) ? reg_bs : 1;
    while (wx * wy * wz * bs > 48 && wx * wy * wz > 1) begin
      if (wz > 1) wz--;
      else if (wy > 1) wy--;
      else wx--;
    end
    put(REQ_START, box_origin(reg_x, wx), box_origin(reg_y, wy), box_origin(reg_z, wz),
        wx, wy, wz);
    steps = wx * wy * wz * bs;
    if (!to_end) steps = $urandom_range(0, steps - 1);
    done = 0;
    if (to_end && regs_ok && steps > 2 && $urandom_range(0, 9) == 0) begin
      // The registers change while the walk is parked between two indices.
      repeat (steps / 2) put_next();
      done = steps / 2;
      settle();
      program_regs(grow(reg_x), grow(reg_y), grow(reg_z), $urandom_range(1, 16));
    end
    repeat (steps - done) put_next();
    if (to_end && $urandom_range(0, 3) == 0) put_next();
  endtask

  task automatic choose_settings();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      program_regs($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 6),
                   $urandom_range(1, 4) + ($urandom_range(0, 63) << BS_W));
    end else if (r < 72) begin
      program_regs($urandom_range(1, 1024), $urandom_range(1, 1024), $urandom_range(1, 1024),
                   $urandom_range(1, 16));
    end else if (r < 87) begin
      program_regs($urandom_range(0, 1) ? 1024 : 1, $urandom_range(0, 1) ? 1024 : 1,
                   $urandom_range(0, 1) ? 1024 : 1, $urandom_range(0, 1) ? 16 : 1);
    end else begin
      case ($urandom_range(0, 4))
        0: program_regs(0, $urandom_range(1, 6), $urandom_range(1, 6), 1);
        1: program_regs($urandom_range(1, 6), $urandom_range(1025, 2047), 3, 2);
        2: program_regs($urandom_range(1, 6), $urandom_range(1, 6), 0, 1);
        3: program_regs(2, 2, 2, $urandom_range(0, 63) << BS_W);
        default: program_regs(2, 2, 2, $urandom_range(17, 31));
      endcase
    end
  endtask

  initial begin
    int r;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset register values: one point, one component.
    put_next();
    put(REQ_START, 0, 0, 0, 1, 1, 1);
    put_next();
    put_next();
    settle();

    program_regs(1024, 1024, 1024, 16);
    put(REQ_START, -1024, -1024, -1024, 1, 1, 1);
    put_next();
    put_next();
    put(REQ_START, 1023, 1023, 1023, 1, 1, 1);
    put_next();
    put(REQ_START, 1023, 0, 0, 1026, 1, 1);
    put_next();
    put(REQ_START, 0, 0, 0, 0, 1, 1);
    put(REQ_START, -1, -1, -1, 2047, 2047, 2047);
    put(REQ_START, -1024, 0, 0, 1024, 1024, 1024);
    put_next();
    settle();

    program_regs(3, 2, 1, 2);
    put(REQ_START, -4, 0, 0, 1, 1, 1);
    put(REQ_START, -3, -2, -1, 9, 6, 3);
    put_next();
    put_next();
    put(REQ_START, 0, 0, 0, 7, 1, 1);
    put(REQ_START, 5, 3, 1, 1, 1, 1);
    put_next();
    put_next();
    put_next();
    settle();

    program_regs(0, 1, 1, 1);
    put(REQ_START, 0, 0, 0, 1, 1, 1);
    settle();
    program_regs(1, 1, 1, 17 + (1 << 10));
    put(REQ_START, 0, 0, 0, 1, 1, 1);

    while (requests_sent < 650) begin
      settle();
      choose_settings();
      repeat ($urandom_range(2, 6)) begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          run_walk(1'b1);
        end else if (r < 75) begin
          run_walk(1'b0);
        end else if (r < 88) begin
          put(REQ_START, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
          repeat ($urandom_range(0, 3)) put_next();
        end else begin
          put_next();
        end
      end
    end

    settle();
    repeat (12) @(posedge clk);
    $display("Transferred %0d requests under %0d register settings; %0d results compared.",
             requests_sent, settings_used, results_seen);
    if (mismatches == 0 && results_seen == requests_sent) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("Timed out with %0d of %0d results seen.", results_seen, requests_sent);
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/phig_pkg.sv
rtl/phig_ctrl.sv
rtl/phig_dp.sv
rtl/periodic_halo_index_generator.sv
tb/phig_checker.sv
tb/periodic_halo_index_generator_tb.sv
